// ===== src/cdclk_pkg.sv =====
// ----------------------------------------------------------------------------
// cdclk_pkg
// Shared types and limits for the calendar clock with tenth-second resolution.
// ----------------------------------------------------------------------------
package cdclk_pkg;

    localparam int YearW   = 8;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int TenthW  = 4;

    localparam int TimeW  = YearW + MonthW + DayW + HourW + MinuteW + SecondW + TenthW;
    localparam int TdataW = ((TimeW + 7) / 8) * 8;

    localparam logic [TenthW-1:0]  TenthMax  = 4'd9;
    localparam logic [SecondW-1:0] SecondMax = 6'd59;
    localparam logic [MinuteW-1:0] MinuteMax = 6'd59;
    localparam logic [HourW-1:0]   HourMax   = 5'd23;
    localparam logic [MonthW-1:0]  MonthMax  = 4'd12;

    localparam logic [DayW-1:0] DaysLong  = 5'd31;
    localparam logic [DayW-1:0] DaysShort = 5'd30;
    localparam logic [DayW-1:0] DaysLeap  = 5'd29;
    localparam logic [DayW-1:0] DaysFeb   = 5'd28;

    localparam logic [MonthW-1:0] MonthFeb = 4'd2;

    // Year offsets of 2100 and 2200: divisible by 4 but not leap
    localparam logic [YearW-1:0] YearCent1 = 8'd100;
    localparam logic [YearW-1:0] YearCent2 = 8'd200;

    localparam logic [YearW-1:0]   ResetYear   = 8'd0;
    localparam logic [MonthW-1:0]  ResetMonth  = 4'd1;
    localparam logic [DayW-1:0]    ResetDay    = 5'd1;
    localparam logic [HourW-1:0]   ResetHour   = 5'd0;
    localparam logic [MinuteW-1:0] ResetMinute = 6'd0;
    localparam logic [SecondW-1:0] ResetSecond = 6'd0;
    localparam logic [TenthW-1:0]  ResetTenth  = 4'd0;

    // Last member sits in the lowest bits
    typedef struct packed {
        logic [TenthW-1:0]  tenth;
        logic [SecondW-1:0] second;
        logic [MinuteW-1:0] minute;
        logic [HourW-1:0]   hour;
        logic [DayW-1:0]    day;
        logic [MonthW-1:0]  month;
        logic [YearW-1:0]   year;
    } time_t;

    localparam time_t ResetTime = '{
        tenth:  ResetTenth,
        second: ResetSecond,
        minute: ResetMinute,
        hour:   ResetHour,
        day:    ResetDay,
        month:  ResetMonth,
        year:   ResetYear
    };

endpackage

// ===== src/cdclk_step.sv =====
// ----------------------------------------------------------------------------
// cdclk_step
// Next calendar time from the current time: load, or one tenth-second tick
// with the carry chain from tenth up to year.
// ----------------------------------------------------------------------------
module cdclk_step (
    input  logic             action,
    input  cdclk_pkg::time_t cur,
    input  cdclk_pkg::time_t load,
    output cdclk_pkg::time_t nxt
);

    logic                  leap;
    logic [4:0]            day_limit;
    logic [4:0]            tenth_inc;
    logic [6:0]            second_inc;
    logic [6:0]            minute_inc;
    logic [5:0]            hour_inc;
    logic [5:0]            day_inc;
    logic [4:0]            month_inc;
    logic                  carry_tenth;
    logic                  carry_second;
    logic                  carry_minute;
    logic                  carry_hour;
    logic                  carry_day;
    logic                  carry_month;
    cdclk_pkg::time_t      ticked;

    always_comb begin
        leap = (cur.year[1:0] == 2'd0) && (cur.year != cdclk_pkg::YearCent1)
            && (cur.year != cdclk_pkg::YearCent2);
        if (cur.month inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
            day_limit = cdclk_pkg::DaysLong;
        end else if (cur.month == cdclk_pkg::MonthFeb) begin
            day_limit = leap ? cdclk_pkg::DaysLeap : cdclk_pkg::DaysFeb;
        end else begin
            day_limit = cdclk_pkg::DaysShort;
        end
    end

    always_comb begin
        tenth_inc    = {1'b0, cur.tenth} + 5'd1;
        carry_tenth  = tenth_inc > {1'b0, cdclk_pkg::TenthMax};

        second_inc   = {1'b0, cur.second} + {6'd0, carry_tenth};
        carry_second = second_inc > {1'b0, cdclk_pkg::SecondMax};

        minute_inc   = {1'b0, cur.minute} + {6'd0, carry_second};
        carry_minute = minute_inc > {1'b0, cdclk_pkg::MinuteMax};

        hour_inc     = {1'b0, cur.hour} + {5'd0, carry_minute};
        carry_hour   = hour_inc > {1'b0, cdclk_pkg::HourMax};

        day_inc      = {1'b0, cur.day} + {5'd0, carry_hour};
        carry_day    = day_inc > {1'b0, day_limit};

        month_inc    = {1'b0, cur.month} + {4'd0, carry_day};
        carry_month  = month_inc > {1'b0, cdclk_pkg::MonthMax};

        ticked.tenth  = carry_tenth  ? '0 : tenth_inc[3:0];
        ticked.second = carry_second ? '0 : second_inc[5:0];
        ticked.minute = carry_minute ? '0 : minute_inc[5:0];
        ticked.hour   = carry_hour   ? '0 : hour_inc[4:0];
        ticked.day    = carry_day    ? cdclk_pkg::ResetDay : day_inc[4:0];
        ticked.month  = carry_month  ? cdclk_pkg::ResetMonth : month_inc[3:0];
        ticked.year   = cur.year + {7'd0, carry_month};

        nxt = action ? load : ticked;
    end

endmodule

// ===== src/calendar_decisecond_clock.sv =====
// ----------------------------------------------------------------------------
// calendar_decisecond_clock
// Calendar clock (year offset from 2000 down to tenth of a second) driven by
// tick and load beats; every beat returns the time after the step.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)                          | tuser
//  s_      | in        | year, month, day, hour, minute, second,     | action
//          |           | tenth, zero pad to 40 bits                  |
//  m_      | out       | year, month, day, hour, minute, second,     | -
//          |           | tenth, zero pad to 40 bits                  |
//
//  One beat per cycle sustained while m_ takes results; a result passes the input
//  register and then the result register, with the combinational carry chain
//  between them.
//  Reset sets year offset 0, month 1, day 1, 00:00:00.0 and empties both
//  registers.
//  A stall on m_ fills the input register, then drops s_tready.
// ----------------------------------------------------------------------------
module calendar_decisecond_clock (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // set_year, set_month, set_day, set_hour, set_minute, set_second, set_tenth
    input  logic [cdclk_pkg::TdataW-1:0] s_tdata,
    // action
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second, cur_tenth
    output logic [cdclk_pkg::TdataW-1:0] m_tdata
);

    logic             in_valid_reg;
    logic             in_action_reg;
    cdclk_pkg::time_t in_time_reg;
    cdclk_pkg::time_t state_reg;
    cdclk_pkg::time_t state_next;
    logic             out_valid_reg;
    cdclk_pkg::time_t out_time_reg;
    logic             advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cdclk_pkg::TdataW - cdclk_pkg::TimeW){1'b0}}, out_time_reg};

    cdclk_step u_step (
        .action (in_action_reg),
        .cur    (state_reg),
        .load   (in_time_reg),
        .nxt    (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= cdclk_pkg::ResetTime;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_time_reg   <= cdclk_pkg::time_t'(s_tdata[cdclk_pkg::TimeW-1:0]);
        end
        if (advance) begin
            out_time_reg <= state_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_time_reg == state_reg))
        else $error("result register differs from clock state");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("clock state moved without a beat");

    a_load_copies: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_action_reg |=> (state_reg == $past(in_time_reg)))
        else $error("load beat not copied into clock state");

endmodule
